// ===== src/e2c_pkg.sv =====
// Shared constants and a helper function for the epoch-seconds to calendar converter.
// No dependencies; used by epoch_seconds_to_calendar_top.
package e2c_pkg;

  // Time and calendar constants.
  localparam int unsigned SECS_LOW_BITS  = 7;      // 86400 = 675 * 2^7
  localparam int unsigned DAY_DIV_ODD    = 675;
  localparam int unsigned DAYS_4Y        = 1461;
  localparam int unsigned DAYS_YEAR      = 365;
  localparam int unsigned SECS_MIN       = 60;
  localparam int unsigned DAYS_WEEK      = 7;

  // Two years of days, which moves the count back to a leap-year start.
  localparam logic [15:0] CYCLE_SHIFT    = 16'd731;
  // The epoch was a Thursday; Monday is day zero.
  localparam logic [15:0] WEEKDAY_BIAS   = 16'd3;
  // Day of the four-year cycle that holds February 29.
  localparam logic [10:0] LEAP_DAY       = 11'd59;
  // Year count in the cycle starts two years before the epoch.
  localparam logic [7:0]  YEAR_BIAS      = 8'd2;
  localparam logic [31:0] LAST_VALID_SEC = 32'd4102444799;

  localparam logic [3:0]  MONTH_LAST     = 4'd11;
  localparam logic [3:0]  MONTH_FEB      = 4'd1;

  // First day of each month within a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    unique case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/e2c_const_div.sv =====
// Three-stage pipelined divider by a constant (reciprocal multiply plus one correction).
// Depends on nothing outside this file; instantiated by epoch_seconds_to_calendar_top.
module e2c_const_div #(
  parameter int XW  = 25,
  parameter int DIV = 675,
  parameter int QW  = 16,
  parameter int RW  = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [XW-1:0] x,
  output logic          valid_out,
  output logic [QW-1:0] quot,
  output logic [RW-1:0] rem
);

  // floor(2^XW / DIV): the estimate is low by at most one.
  localparam longint unsigned MULT = (64'd1 << XW) / DIV;
  localparam int MW = $clog2(MULT + 1);
  localparam int PW = XW + MW;
  localparam logic [MW-1:0] MULT_X = MW'(MULT);
  localparam logic [XW-1:0] DIV_X  = XW'(DIV);

  logic          v_a, v_b, v_c;
  logic [XW-1:0] x_a, x_b;
  logic [PW-1:0] prod_a;
  logic [XW-1:0] q_b, m_b, q_c, r_c;
  logic [XW-1:0] q_est;
  logic [XW-1:0] diff;

  assign q_est = XW'(prod_a >> XW);
  assign diff  = x_b - m_b;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
    end else if (en) begin
      v_a <= valid_in;
      v_b <= v_a;
      v_c <= v_b;
    end
  end

  // Stage a multiplies by the reciprocal, stage b forms the estimate times the divisor,
  // and stage c corrects the quotient once.
  always_ff @(posedge clk) begin
    if (en) begin
      x_a    <= x;
      prod_a <= PW'(x) * PW'(MULT_X);
      x_b    <= x_a;
      q_b    <= q_est;
      m_b    <= q_est * DIV_X;
      if (diff >= DIV_X) begin
        q_c <= q_b + 1'b1;
        r_c <= diff - DIV_X;
      end else begin
        q_c <= q_b;
        r_c <= diff;
      end
    end
  end

  assign valid_out = v_c;
  assign quot      = q_c[QW-1:0];
  assign rem       = r_c[RW-1:0];

endmodule

// ===== src/epoch_seconds_to_calendar_top.sv =====
// Top level of the epoch-seconds to calendar converter.
// Depends on e2c_pkg and e2c_const_div.
//
// Converts a 32-bit count of seconds since 1970-01-01 into year offset, month, day,
// hour, minute, second and weekday, with a flag for inputs past the end of 2099. The
// block takes one transaction per clock while item_stall is low. Each item passes 13
// register stages, the last being the output register: three levels of three-stage
// constant dividers (seconds to days, days to four-year cycle, cycle day to year)
// plus the stages between them. While a result waits on result_stall the whole
// pipeline holds and item_stall is raised. Dates after 2099 follow the plain four-year
// leap rule.
module epoch_seconds_to_calendar_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] epoch_seconds,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  year_offset,
  output logic [3:0]  month_index,
  output logic [4:0]  day_index,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute,
  output logic [2:0]  weekday,
  output logic        in_range
);

  typedef struct packed {
    logic [5:0] cycle;
    logic       leap;
    logic [2:0] wday;
    logic [5:0] sec;
    logic       inr;
  } side_t;

  logic en;

  // The pipeline moves whenever the output register is free or being drained.
  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;

  // Level 1: seconds to days and time of day.
  logic        a_valid;
  logic [15:0] a_days;
  logic [9:0]  a_rem;
  logic [6:0]  lo_dly  [3];
  logic        inr_dly [3];

  e2c_const_div #(.XW(25), .DIV(e2c_pkg::DAY_DIV_ODD), .QW(16), .RW(10)) u_div_day (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (item_valid),
    .x         (epoch_seconds[31:e2c_pkg::SECS_LOW_BITS]),
    .valid_out (a_valid),
    .quot      (a_days),
    .rem       (a_rem)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lo_dly[0]  <= epoch_seconds[e2c_pkg::SECS_LOW_BITS-1:0];
      inr_dly[0] <= (epoch_seconds <= e2c_pkg::LAST_VALID_SEC);
      lo_dly[1]  <= lo_dly[0];
      inr_dly[1] <= inr_dly[0];
      lo_dly[2]  <= lo_dly[1];
      inr_dly[2] <= inr_dly[1];
    end
  end

  // Stage 4: cycle shift, weekday bias and time of day.
  logic        s4_valid;
  logic [15:0] s4_shift;
  logic [15:0] s4_wkx;
  logic [16:0] s4_tod;
  logic        s4_inr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_shift <= a_days + e2c_pkg::CYCLE_SHIFT;
      s4_wkx   <= a_days + e2c_pkg::WEEKDAY_BIAS;
      s4_tod   <= {a_rem, lo_dly[2]};
      s4_inr   <= inr_dly[2];
    end
  end

  // Level 2: four-year cycle, weekday and minutes of the day in parallel.
  logic        b_valid;
  logic [5:0]  b_cycle;
  logic [10:0] b_dcyc;
  logic [2:0]  c_wday;
  logic [10:0] d_mins;
  logic [5:0]  d_sec;
  logic        inr2_dly [3];

  e2c_const_div #(.XW(16), .DIV(e2c_pkg::DAYS_4Y), .QW(6), .RW(11)) u_div_cycle (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s4_valid),
    .x         (s4_shift),
    .valid_out (b_valid),
    .quot      (b_cycle),
    .rem       (b_dcyc)
  );

  e2c_const_div #(.XW(16), .DIV(e2c_pkg::DAYS_WEEK), .QW(1), .RW(3)) u_div_week (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s4_valid),
    .x         (s4_wkx),
    .valid_out (),
    .quot      (),
    .rem       (c_wday)
  );

  e2c_const_div #(.XW(17), .DIV(e2c_pkg::SECS_MIN), .QW(11), .RW(6)) u_div_sec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s4_valid),
    .x         (s4_tod),
    .valid_out (),
    .quot      (d_mins),
    .rem       (d_sec)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      inr2_dly[0] <= s4_inr;
      inr2_dly[1] <= inr2_dly[0];
      inr2_dly[2] <= inr2_dly[1];
    end
  end

  // Stage 8: fold the leap day out so every year looks like a common year.
  logic        s8_valid;
  logic [10:0] s8_d2;
  logic [10:0] s8_mins;
  side_t       s8_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_d2         <= (b_dcyc >= e2c_pkg::LEAP_DAY) ? b_dcyc - 11'd1 : b_dcyc;
      s8_mins       <= d_mins;
      s8_side.cycle <= b_cycle;
      s8_side.leap  <= (b_dcyc == e2c_pkg::LEAP_DAY);
      s8_side.wday  <= c_wday;
      s8_side.sec   <= d_sec;
      s8_side.inr   <= inr2_dly[2];
    end
  end

  // Level 3: year within the cycle, and hours and minutes.
  logic        e_valid;
  logic [1:0]  e_yic;
  logic [8:0]  e_rem;
  logic [4:0]  f_hour;
  logic [5:0]  f_min;
  side_t       side_dly [3];

  e2c_const_div #(.XW(11), .DIV(e2c_pkg::DAYS_YEAR), .QW(2), .RW(9)) u_div_year (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s8_valid),
    .x         (s8_d2),
    .valid_out (e_valid),
    .quot      (e_yic),
    .rem       (e_rem)
  );

  e2c_const_div #(.XW(11), .DIV(e2c_pkg::SECS_MIN), .QW(5), .RW(6)) u_div_min (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid_in  (s8_valid),
    .x         (s8_mins),
    .valid_out (),
    .quot      (f_hour),
    .rem       (f_min)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_dly[0] <= s8_side;
      side_dly[1] <= side_dly[0];
      side_dly[2] <= side_dly[1];
    end
  end

  // Stage 12: month from the table of month starts, and the year count.
  logic        s12_valid;
  logic [7:0]  s12_year;
  logic [3:0]  s12_month;
  logic [8:0]  s12_rem;
  logic [4:0]  s12_hour;
  logic [5:0]  s12_min;
  side_t       s12_side;
  logic [3:0]  month_next;

  always_comb begin
    month_next = 4'd0;
    for (int i = 1; i <= 11; i++) begin
      if (e_rem >= e2c_pkg::month_start(4'(i))) begin
        month_next = month_next + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_valid <= 1'b0;
    end else if (en) begin
      s12_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s12_year  <= {side_dly[2].cycle, 2'b00} + {6'd0, e_yic} - e2c_pkg::YEAR_BIAS;
      s12_month <= month_next;
      s12_rem   <= e_rem;
      s12_hour  <= f_hour;
      s12_min   <= f_min;
      s12_side  <= side_dly[2];
    end
  end

  // Stage 13: day of month and the output register.
  logic [8:0] day_full;

  assign day_full = s12_rem - e2c_pkg::month_start(s12_month) + {8'd0, s12_side.leap};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= s12_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      year_offset      <= s12_year;
      month_index      <= s12_month;
      day_index        <= day_full[4:0];
      hour_of_day      <= s12_hour;
      minute_of_hour   <= s12_min;
      second_of_minute <= s12_side.sec;
      weekday          <= s12_side.wday;
      in_range         <= s12_side.inr;
    end
  end

`ifndef NO_ASSERTIONS
  // The month search never runs past December.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> month_index <= e2c_pkg::MONTH_LAST)
    else $error("month index out of range");

  // The constant dividers leave every time field inside its range.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (hour_of_day < 5'd24) && (minute_of_hour < 6'd60) &&
                     (second_of_minute < 6'd60) && (weekday < 3'd7))
    else $error("time of day or weekday out of range");

  // February reaches day index 28 only on the leap day.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (month_index == e2c_pkg::MONTH_FEB) |-> day_index <= 5'd28)
    else $error("February day index too large");

  // The range flag agrees with the year that comes out.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (in_range == (year_offset <= 8'd129)))
    else $error("range flag disagrees with year");

  // Day indices never exceed 30, the last day of the longest month.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> day_index <= 5'd30)
    else $error("day index out of range");
`endif

endmodule

// ===== tb/tb_epoch_seconds_to_calendar_top.sv =====
// Self-checking testbench for epoch_seconds_to_calendar_top: drives timestamps, predicts each
// calendar result in a scoreboard class and compares every field in order of arrival.
// Depends only on src/epoch_seconds_to_calendar_top.sv and the package and divider it uses.
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar_top;

  localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
  localparam logic [31:0] DAYS_COMMON     = 32'd365;
  localparam logic [31:0] DAYS_PER_CYCLE  = 32'd1461;
  // Two years of days: one common year and one leap year.
  localparam logic [31:0] CYCLE_SHIFT     = 32'd731;
  localparam logic [31:0] FEB29_OF_CYCLE  = 32'd59;
  localparam logic [31:0] LAST_IN_RANGE   = 32'd4102444799;
  localparam logic [31:0] LAST_SAFE_DAY   = 32'd49709;
  localparam int          RANDOM_ITEMS    = 875;
  localparam int          QUIET_TAIL      = 150;
  localparam int          MIDRUN_DRAIN_AT = 500;
  localparam int          LONG_HOLD_AT    = 300;
  localparam int          LONG_HOLD_LEN   = 200;
  localparam int          SETTLE_CYCLES   = 30;

  // Dates at the edges of the range, around leap days and around the end of 2099.
  localparam int CORNER_COUNT = 20;
  localparam logic [31:0] CORNER_SECS [CORNER_COUNT] = '{
    32'd0,          32'hFFFF_FFFF,  32'd86399,      32'd86400,
    32'd31535999,   32'd63071999,   32'd68169600,   32'd68169599,
    32'd68256000,   32'd94694400,   32'd951782399,  32'd951782400,
    32'd951868800,  32'd978307199,  32'd4102444799, 32'd4102444800,
    32'd4107542400, 32'h8000_0000,  32'hAAAA_AAAA,  32'h5555_5555
  };

  typedef struct packed {
    logic [7:0] year_offset;
    logic [3:0] month_index;
    logic [4:0] day_index;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [2:0] weekday;
    logic       in_range;
  } calendar_t;

  // Holds the dates still owed by the block and checks each one as it comes out.
  class calendar_scoreboard;
    calendar_t   pending_dates[$];
    logic [31:0] pending_secs[$];
    int          mismatches;
    int          stray_results;
    int          checked;
    int          noted;
    int          past_2099;

    // Works out the civil date the block should return for one timestamp.
    function calendar_t civil_date_of(logic [31:0] secs);
      calendar_t   c;
      logic [31:0] days, tod, shifted, cycle_idx, day_of_cycle, rem, month, year;
      logic        leap_hit;
      byte unsigned month_days [12];
      month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      days = secs / SECS_PER_DAY;
      tod = secs % SECS_PER_DAY;
      shifted = days + CYCLE_SHIFT;
      cycle_idx = shifted / DAYS_PER_CYCLE;
      day_of_cycle = shifted % DAYS_PER_CYCLE;

      // Fold February 29 out so that each year of the cycle looks common.
      leap_hit = 1'b0;
      if (day_of_cycle >= FEB29_OF_CYCLE) begin
        leap_hit = (day_of_cycle == FEB29_OF_CYCLE);
        day_of_cycle = day_of_cycle - 1;
      end

      rem = day_of_cycle % DAYS_COMMON;
      month = 0;
      while (month < 11 && rem >= month_days[month]) begin
        rem = rem - month_days[month];
        month = month + 1;
      end
      year = cycle_idx * 4 + day_of_cycle / DAYS_COMMON - 2;

      c.year_offset      = 8'(year);
      c.month_index      = 4'(month);
      c.day_index        = 5'(rem + leap_hit);
      c.hour_of_day      = 5'(tod / 3600);
      c.minute_of_hour   = 6'(tod / 60 % 60);
      c.second_of_minute = 6'(tod % 60);
      c.weekday          = 3'((days + 3) % 7);
      c.in_range         = (secs <= LAST_IN_RANGE);
      return c;
    endfunction

    function void note_timestamp(logic [31:0] secs);
      pending_dates.push_back(civil_date_of(secs));
      pending_secs.push_back(secs);
      noted++;
      if (secs > LAST_IN_RANGE) past_2099++;
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction

    function void compare_field(string name, logic [31:0] secs, logic [7:0] want,
                                logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH %s for %0d s: expected %0d, got %0d", name, secs, want, got);
      end
    endfunction

    function void check_date(calendar_t got);
      calendar_t   want;
      logic [31:0] secs;
      if (pending_dates.size() == 0) begin
        stray_results++;
        $display("ERROR: result with no transaction waiting for it");
        return;
      end
      want = pending_dates.pop_front();
      secs = pending_secs.pop_front();
      checked++;
      compare_field("year_offset", secs, want.year_offset, got.year_offset);
      compare_field("month_index", secs, want.month_index, got.month_index);
      compare_field("day_index", secs, want.day_index, got.day_index);
      compare_field("hour_of_day", secs, want.hour_of_day, got.hour_of_day);
      compare_field("minute_of_hour", secs, want.minute_of_hour, got.minute_of_hour);
      compare_field("second_of_minute", secs, want.second_of_minute, got.second_of_minute);
      compare_field("weekday", secs, want.weekday, got.weekday);
      compare_field("in_range", secs, want.in_range, got.in_range);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [31:0] epoch_seconds;
  logic        result_valid;
  logic        result_stall;
  logic [7:0]  year_offset;
  logic [3:0]  month_index;
  logic [4:0]  day_index;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;
  logic [2:0]  weekday;
  logic        in_range;

  calendar_scoreboard board = new();
  bit idling_on = 1'b1;

  epoch_seconds_to_calendar_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .epoch_seconds    (epoch_seconds),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .year_offset      (year_offset),
    .month_index      (month_index),
    .day_index        (day_index),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .weekday          (weekday),
    .in_range         (in_range)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offers one timestamp, with an occasional idle burst first, and waits until it is taken.
  task automatic send_timestamp(input logic [31:0] secs);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (item_stall !== 1'b0);
    board.note_timestamp(secs);
  endtask

  // Stops offering and waits until every outstanding date has come back.
  task automatic wait_for_drain();
    item_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  // Random timestamps, weighted toward day edges, leap days and the end of 2099.
  function automatic logic [31:0] random_timestamp();
    logic [31:0] days, tod;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6: begin
        days = $urandom_range(0, LAST_SAFE_DAY);
        tod = $urandom_range(0, 1) ? $urandom_range(0, 3) : SECS_PER_DAY - 1 - $urandom_range(0, 3);
        return days * SECS_PER_DAY + tod;
      end
      7, 8: begin
        days = $urandom_range(1, 34) * DAYS_PER_CYCLE + $urandom_range(57, 61) - CYCLE_SHIFT;
        tod = $urandom_range(0, SECS_PER_DAY - 1);
        return days * SECS_PER_DAY + tod;
      end
      default: return LAST_IN_RANGE - 100 + $urandom_range(0, 200);
    endcase
  endfunction

  // Result side: checks each completed transaction and stalls in random bursts, with
  // one long hold-off partway through so that the pipeline backs up into the input.
  initial begin : result_sink
    int  stall_left;
    bit  long_hold_done;
    calendar_t got;
    result_stall   = 1'b0;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && !result_stall) begin
        got = {year_offset, month_index, day_index, hour_of_day, minute_of_hour,
               second_of_minute, weekday, in_range};
        board.check_date(got);
      end

      if (!long_hold_done && board.checked >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD_LEN;
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    rst           = 1'b1;
    item_valid    = 1'b0;
    epoch_seconds = 32'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (CORNER_SECS[i]) send_timestamp(CORNER_SECS[i]);
    wait_for_drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == MIDRUN_DRAIN_AT) wait_for_drain();
      if (i == RANDOM_ITEMS - QUIET_TAIL) idling_on = 1'b0;
      send_timestamp(random_timestamp());
    end
    item_valid <= 1'b0;

    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d timestamps (%0d past the end of 2099), %0d results checked.",
             board.noted, board.past_2099, board.checked);
    $display("Field mismatches: %0d, stray results: %0d, still owed: %0d.",
             board.mismatches, board.stray_results, board.pending());
    if (board.mismatches == 0 && board.stray_results == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Timeout with %0d results still owed.", board.pending());
    $display("Verification failed");
    $finish;
  end

endmodule
